### rtl/kabf_pkg.sv
`default_nettype none
package kabf_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CFG_WIDTH  = 31;
  localparam int DT_WIDTH   = FRAC_BITS + 1;
  localparam int IDX_WIDTH  = 2;

  // divider runs one quotient bit per cycle over the scaled dividend
  localparam int DIV_STEPS  = DATA_WIDTH + FRAC_BITS;
  localparam int CNT_WIDTH  = $clog2(DIV_STEPS);
  localparam logic [CNT_WIDTH-1:0] DIV_LAST = CNT_WIDTH'(DIV_STEPS - 1);

  // register indexes
  localparam logic [IDX_WIDTH-1:0] REG_ANGLE_NOISE   = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_BIAS_NOISE    = 2'd1;
  localparam logic [IDX_WIDTH-1:0] REG_MEASURE_NOISE = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6,
    ST_DIV, ST_DEND,
    ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6, ST_C7,
    ST_FIN
  } state_e;

  typedef enum logic [4:0] {
    CMD_NOP, CMD_LOAD, CMD_M1, CMD_M2, CMD_M3, CMD_M4, CMD_M5, CMD_M6,
    CMD_DIV, CMD_DEND,
    CMD_C1, CMD_C2, CMD_C3, CMD_C4, CMD_C5, CMD_C6, CMD_C7,
    CMD_OUT
  } cmd_e;

endpackage
`default_nettype wire

### rtl/kabf_ctrl.sv
`default_nettype none
module kabf_ctrl (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output kabf_pkg::cmd_e cmd_o
);
  import kabf_pkg::*;

  state_e state_q, state_d;
  logic [CNT_WIDTH-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;

  // state, divide counter and result flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = CMD_NOP;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = ST_M1;
        end
      end
      ST_M1: begin cmd_o = CMD_M1; state_d = ST_M2; end
      ST_M2: begin cmd_o = CMD_M2; state_d = ST_M3; end
      ST_M3: begin cmd_o = CMD_M3; state_d = ST_M4; end
      ST_M4: begin cmd_o = CMD_M4; state_d = ST_M5; end
      ST_M5: begin cmd_o = CMD_M5; state_d = ST_M6; end
      ST_M6: begin
        cmd_o   = CMD_M6;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o = CMD_DIV;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) state_d = ST_DEND;
      end
      ST_DEND: begin cmd_o = CMD_DEND; state_d = ST_C1; end
      ST_C1: begin cmd_o = CMD_C1; state_d = ST_C2; end
      ST_C2: begin cmd_o = CMD_C2; state_d = ST_C3; end
      ST_C3: begin cmd_o = CMD_C3; state_d = ST_C4; end
      ST_C4: begin cmd_o = CMD_C4; state_d = ST_C5; end
      ST_C5: begin cmd_o = CMD_C5; state_d = ST_C6; end
      ST_C6: begin cmd_o = CMD_C6; state_d = ST_C7; end
      ST_C7: begin cmd_o = CMD_C7; state_d = ST_FIN; end
      ST_FIN: begin
        // load the result once the previous one has been transferred
        if (!out_valid_q || out_ready_i) begin
          cmd_o       = CMD_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

### rtl/kabf_datapath.sv
`default_nettype none
module kabf_datapath (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  kabf_pkg::cmd_e cmd_i,
  input  wire  cfg_valid_i,
  input  wire  [kabf_pkg::IDX_WIDTH-1:0]  cfg_index_i,
  input  wire  [kabf_pkg::CFG_WIDTH-1:0]  cfg_data_i,
  input  wire  [kabf_pkg::DATA_WIDTH-1:0] measured_angle_i,
  input  wire  [kabf_pkg::DATA_WIDTH-1:0] gyro_rate_i,
  input  wire  [kabf_pkg::DT_WIDTH-1:0]   time_step_i,
  output logic [kabf_pkg::DATA_WIDTH-1:0] angle_estimate_o,
  output logic [kabf_pkg::DATA_WIDTH-1:0] corrected_rate_o,
  output logic gain_zeroed_o
);
  import kabf_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int NW = DATA_WIDTH + FRAC_BITS;

  logic [CFG_WIDTH-1:0] an_q, bn_q, mn_q;
  logic [DW-1:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  logic [DW-1:0] meas_q, rate_q, y_q, s_q, t_q, u_q, k0_q, k1_q;
  logic [DT_WIDTH-1:0] dt_q;
  logic [2*DW-1:0] prod_q;
  logic [DW-1:0] mul_a, mul_b, fx, dtw;
  logic [NW-1:0] num0_q, num1_q;
  logic [DW-1:0] rem0_q, rem1_q, q0_q, q1_q;
  logic neg0_q, neg1_q;
  logic [DW-1:0] trial0, trial1, mag0, mag1;
  logic ge0, ge1, zeroed;

  assign dtw    = {{(DW-DT_WIDTH){1'b0}}, dt_q};
  assign fx     = prod_q[FRAC_BITS+DW-1:FRAC_BITS];
  assign zeroed = (s_q == '0) || s_q[DW-1];
  assign trial0 = {rem0_q[DW-2:0], num0_q[NW-1]};
  assign trial1 = {rem1_q[DW-2:0], num1_q[NW-1]};
  assign ge0    = trial0 >= s_q;
  assign ge1    = trial1 >= s_q;
  assign mag0   = p00_q[DW-1] ? (~p00_q + 1'b1) : p00_q;
  assign mag1   = p10_q[DW-1] ? (~p10_q + 1'b1) : p10_q;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i)
      CMD_M1: begin mul_a = dtw; mul_b = rate_q; end
      CMD_M2: begin mul_a = dtw; mul_b = p11_q; end
      CMD_M3: begin mul_a = {1'b0, bn_q}; mul_b = dtw; end
      CMD_M4: begin mul_a = dtw; mul_b = t_q; end
      CMD_C1: begin mul_a = k0_q; mul_b = y_q; end
      CMD_C2: begin mul_a = k1_q; mul_b = y_q; end
      CMD_C3: begin mul_a = k0_q; mul_b = p00_q; end
      CMD_C4: begin mul_a = k0_q; mul_b = p01_q; end
      CMD_C5: begin mul_a = k1_q; mul_b = p00_q; end
      CMD_C6: begin mul_a = k1_q; mul_b = p01_q; end
      default: ;
    endcase
  end

  // product register
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(mul_a) * $signed(mul_b);
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      an_q <= '0;
      bn_q <= '0;
      mn_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ANGLE_NOISE:   an_q <= cfg_data_i;
        REG_BIAS_NOISE:    bn_q <= cfg_data_i;
        REG_MEASURE_NOISE: mn_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q  <= '0;
      bias_q <= '0;
      p00_q  <= '0;
      p01_q  <= '0;
      p10_q  <= '0;
      p11_q  <= '0;
    end else begin
      case (cmd_i)
        CMD_M2: ang_q <= ang_q + fx;
        CMD_M3: begin
          p01_q <= p01_q - fx;
          p10_q <= p10_q - fx;
        end
        CMD_M4: p11_q <= p11_q + fx;
        CMD_M5: p00_q <= p00_q + fx;
        CMD_C2: ang_q  <= ang_q + fx;
        CMD_C3: bias_q <= bias_q + fx;
        CMD_C6: begin
          p10_q <= p10_q - fx;
          p00_q <= p00_q - t_q;
        end
        CMD_C7: begin
          p11_q <= p11_q - fx;
          p01_q <= p01_q - u_q;
        end
        default: ;
      endcase
    end
  end

  // working registers and gain divider
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        meas_q <= measured_angle_i;
        dt_q   <= time_step_i;
        rate_q <= gyro_rate_i - bias_q;
      end
      CMD_M3: t_q <= fx - p01_q - p10_q + {1'b0, an_q};
      CMD_M6: begin
        y_q    <= meas_q - ang_q;
        s_q    <= p00_q + {1'b0, mn_q};
        neg0_q <= p00_q[DW-1];
        neg1_q <= p10_q[DW-1];
        num0_q <= {mag0, {FRAC_BITS{1'b0}}};
        num1_q <= {mag1, {FRAC_BITS{1'b0}}};
        rem0_q <= '0;
        rem1_q <= '0;
        q0_q   <= '0;
        q1_q   <= '0;
      end
      CMD_DIV: begin
        num0_q <= {num0_q[NW-2:0], 1'b0};
        num1_q <= {num1_q[NW-2:0], 1'b0};
        rem0_q <= ge0 ? (trial0 - s_q) : trial0;
        rem1_q <= ge1 ? (trial1 - s_q) : trial1;
        q0_q   <= {q0_q[DW-2:0], ge0};
        q1_q   <= {q1_q[DW-2:0], ge1};
      end
      CMD_DEND: begin
        k0_q <= zeroed ? '0 : (neg0_q ? (~q0_q + 1'b1) : q0_q);
        k1_q <= zeroed ? '0 : (neg1_q ? (~q1_q + 1'b1) : q1_q);
      end
      CMD_C4: t_q <= fx;
      CMD_C5: u_q <= fx;
      CMD_OUT: begin
        angle_estimate_o <= ang_q;
        corrected_rate_o <= rate_q;
        gain_zeroed_o    <= zeroed;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### rtl/kalman_angle_bias_filter_unit.sv
`default_nettype none
// One-axis angle/gyro-bias Kalman filter in signed Q16.16. Each transferred sample runs
// predict and correct on the held angle, bias and 2x2 covariance and yields one result.
// After the input transfer an item runs 6 predict steps around the shared 32x32
// multiplier, the two gain divides running side by side one quotient bit per cycle, a
// step to settle the gain signs, 7 correction steps and the result load. A new sample
// is taken as soon as the unit is idle, even while the last result still waits to be
// transferred; the next result then waits in the load step until the output register
// frees up.
// Configuration writes (cfg_ready_o is always high) belong between items; unknown
// register indexes are ignored.
module kalman_angle_bias_filter_unit (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  cfg_valid_i,
  output logic cfg_ready_o,
  input  wire  [kabf_pkg::IDX_WIDTH-1:0]  cfg_index_i,
  input  wire  [kabf_pkg::CFG_WIDTH-1:0]  cfg_data_i,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  wire  [kabf_pkg::DATA_WIDTH-1:0] measured_angle_i,
  input  wire  [kabf_pkg::DATA_WIDTH-1:0] gyro_rate_i,
  input  wire  [kabf_pkg::DT_WIDTH-1:0]   time_step_i,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output logic [kabf_pkg::DATA_WIDTH-1:0] angle_estimate_o,
  output logic [kabf_pkg::DATA_WIDTH-1:0] corrected_rate_o,
  output logic gain_zeroed_o
);
  import kabf_pkg::*;

  cmd_e cmd;

  assign cfg_ready_o = 1'b1;

  // sequencer
  kabf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  kabf_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .measured_angle_i (measured_angle_i),
    .gyro_rate_i      (gyro_rate_i),
    .time_step_i      (time_step_i),
    .angle_estimate_o (angle_estimate_o),
    .corrected_rate_o (corrected_rate_o),
    .gain_zeroed_o    (gain_zeroed_o)
  );

endmodule
`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import kabf_pkg::*;

  localparam logic [IDX_WIDTH-1:0] REG_UNUSED = 2'd3;
  localparam logic [CFG_WIDTH-1:0] NOISE_MAX  = {CFG_WIDTH{1'b1}};
  localparam int DRAIN_CYCLES = 80;

  typedef logic signed [DATA_WIDTH-1:0] q_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] angle;
    logic [DATA_WIDTH-1:0] rate;
    logic                  zeroed;
  } filt_result_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [IDX_WIDTH-1:0] cfg_index_i = '0;
  logic [CFG_WIDTH-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic [DATA_WIDTH-1:0] measured_angle_i = '0;
  logic [DATA_WIDTH-1:0] gyro_rate_i = '0;
  logic [DT_WIDTH-1:0] time_step_i = '0;
  logic out_ready_i = 1'b0;
  wire cfg_ready_o, in_ready_o, out_valid_o, gain_zeroed_o;
  wire [DATA_WIDTH-1:0] angle_estimate_o, corrected_rate_o;

  kalman_angle_bias_filter_unit dut (
    .clk_i(clk), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .measured_angle_i(measured_angle_i), .gyro_rate_i(gyro_rate_i),
    .time_step_i(time_step_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .angle_estimate_o(angle_estimate_o), .corrected_rate_o(corrected_rate_o),
    .gain_zeroed_o(gain_zeroed_o)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // filter state mirrored by the predictor
  q_t filt_angle, filt_bias;
  q_t cov [4];
  q_t angle_noise, bias_noise, measure_noise;

  filt_result_t pending_results [$];
  int errors = 0;
  int n_results = 0;
  int n_zeroed = 0;
  int n_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  // Q16.16 multiply, floor rounding, wrap to 32 bits
  function automatic q_t qmul(q_t a, q_t b);
    longint p;
    p = longint'(a) * longint'(b);
    p = p >>> FRAC_BITS;
    return p[DATA_WIDTH-1:0];
  endfunction

  // gain divide, truncated toward zero; s known positive
  function automatic q_t gain_div(q_t p, q_t s);
    longint mag, q;
    mag = (p < 0) ? -longint'(p) : longint'(p);
    q = (mag <<< FRAC_BITS) / longint'(s);
    if (p < 0) q = -q;
    return q[DATA_WIDTH-1:0];
  endfunction

  function automatic filt_result_t filter_step(q_t meas, q_t gyro, logic [DT_WIDTH-1:0] dt_in);
    q_t dt, rate, p00, p01, p10, p11, t, y, s, k0, k1;
    filt_result_t r;
    dt = q_t'({{(DATA_WIDTH-DT_WIDTH){1'b0}}, dt_in});
    rate = gyro - filt_bias;
    filt_angle = filt_angle + qmul(dt, rate);
    p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
    t = qmul(dt, p11) - p01 - p10 + angle_noise;
    p00 = p00 + qmul(dt, t);
    p01 = p01 - qmul(dt, p11);
    p10 = p10 - qmul(dt, p11);
    p11 = p11 + qmul(bias_noise, dt);
    y = meas - filt_angle;
    s = p00 + measure_noise;
    r.zeroed = (s <= 0);
    k0 = '0;
    k1 = '0;
    if (!r.zeroed) begin
      k0 = gain_div(p00, s);
      k1 = gain_div(p10, s);
    end
    filt_angle = filt_angle + qmul(k0, y);
    filt_bias = filt_bias + qmul(k1, y);
    // correction uses the predicted P00 and P01
    cov[0] = p00 - qmul(k0, p00);
    cov[1] = p01 - qmul(k0, p01);
    cov[2] = p10 - qmul(k1, p00);
    cov[3] = p11 - qmul(k1, p01);
    r.angle = filt_angle;
    r.rate = rate;
    return r;
  endfunction

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    filt_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: angle %h rate %h zeroed %b",
                 $time, angle_estimate_o, corrected_rate_o, gain_zeroed_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want.zeroed) n_zeroed++;
        if (angle_estimate_o !== want.angle) begin
          $display("%0t: angle_estimate expected %h got %h", $time, want.angle,
                   angle_estimate_o);
          errors++;
        end
        if (corrected_rate_o !== want.rate) begin
          $display("%0t: corrected_rate expected %h got %h", $time, want.rate,
                   corrected_rate_o);
          errors++;
        end
        if (gain_zeroed_o !== want.zeroed) begin
          $display("%0t: gain_zeroed expected %b got %b", $time, want.zeroed,
                   gain_zeroed_o);
          errors++;
        end
      end
    end
  end

  // one sample transfer; valid stays up if the next one follows at once
  task automatic send_sample(q_t meas, q_t gyro, logic [DT_WIDTH-1:0] dt);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    measured_angle_i <= meas;
    gyro_rate_i <= gyro;
    time_step_i <= dt;
    do @(posedge clk); while (!in_ready_o);
    pending_results.push_back(filter_step(meas, gyro, dt));
    n_sent++;
  endtask

  task automatic wait_drained();
    int guard;
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_results.size() > 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_ANGLE_NOISE:   angle_noise = q_t'({1'b0, val});
      REG_BIAS_NOISE:    bias_noise = q_t'({1'b0, val});
      REG_MEASURE_NOISE: measure_noise = q_t'({1'b0, val});
      default: ;
    endcase
  endtask

  task automatic set_noise(logic [CFG_WIDTH-1:0] a, logic [CFG_WIDTH-1:0] b,
                           logic [CFG_WIDTH-1:0] m);
    wait_drained();
    write_reg(REG_ANGLE_NOISE, a);
    write_reg(REG_BIAS_NOISE, b);
    write_reg(REG_MEASURE_NOISE, m);
  endtask

  function automatic logic [CFG_WIDTH-1:0] rand_noise();
    case ($urandom_range(5))
      0: return '0;
      1: return NOISE_MAX;
      2: return CFG_WIDTH'($urandom);
      default: return CFG_WIDTH'($urandom_range(32'h0002_0000));
    endcase
  endfunction

  function automatic q_t rand_value();
    case ($urandom_range(5))
      0: return q_t'($urandom);
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return q_t'($signed($urandom_range(32'h00B4_0000)) - 32'sh005A_0000);
    endcase
  endfunction

  function automatic logic [DT_WIDTH-1:0] rand_dt();
    case ($urandom_range(9))
      0: return DT_WIDTH'($urandom);
      1: return 17'd65536;
      2: return '0;
      default: return DT_WIDTH'($urandom_range(32'd1000));
    endcase
  endfunction

  // extremes, zero-variance case, oversized step, ignored index
  task automatic test_directed();
    send_sample(32'h0001_0000, 32'h0000_8000, 17'd655);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 17'd65536);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 17'h1FFFF);
    set_noise(31'd66, 31'd200, 31'h0000_8000);
    write_reg(REG_UNUSED, NOISE_MAX);
    send_sample(32'h0000_0000, 32'h0000_0000, 17'd0);
    send_sample(32'h0005_0000, 32'hFFFF_0000, 17'd655);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'd65536);
    send_sample(32'h8000_0000, 32'h8000_0000, 17'h1FFFF);
    send_sample(32'hFFFF_FFFF, 32'h0000_0001, 17'd1);
    set_noise(NOISE_MAX, NOISE_MAX, NOISE_MAX);
    send_sample(32'h1234_5678, 32'h8765_4321, 17'd65536);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF, 17'd65536);
    send_sample(32'h0000_0000, 32'h0000_0000, 17'h1FFFF);
    set_noise('0, '0, '0);
    send_sample(32'h0001_0000, 32'h0001_0000, 17'd100);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000, 17'd65536);
  endtask

  task automatic test_random(int n_items, int idle_pct, int stall_pct);
    set_noise(rand_noise(), rand_noise(), rand_noise());
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 60 == 59) set_noise(rand_noise(), rand_noise(), rand_noise());
      send_sample(rand_value(), rand_value(), rand_dt());
    end
  endtask

  // long receiver hold-off with the sender pushing, then a full pause
  task automatic test_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_noise(31'd66, 31'd200, 31'h0000_8000);
    hold_req = 400;
    for (int i = 0; i < 8; i++) send_sample(rand_value(), rand_value(), rand_dt());
    wait_drained();
    for (int i = 0; i < 4; i++) send_sample(rand_value(), rand_value(), rand_dt());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    filt_angle = '0;
    filt_bias = '0;
    foreach (cov[i]) cov[i] = '0;
    angle_noise = '0;
    bias_noise = '0;
    measure_noise = '0;
    test_directed();
    test_random(180, 0, 0);
    test_random(180, 59, 0);
    test_random(180, 0, 59);
    test_random(180, 30, 30);
    test_pressure();
    wait_drained();
    $display("Covered %0d samples, %0d results (%0d with zeroed gain),", n_sent, n_results,
             n_zeroed);
    $display("noise settings from zero to full scale, idle/stall phases and hold-offs.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
